// ===== rtl/afo_pkg.sv =====
package afo_pkg;

  localparam int unsigned MAX_BYTES = 8;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned KIND_W    = 4;
  localparam int unsigned SIZE_W    = 4;

  localparam logic [KIND_W-1:0] OP_ADD  = 4'd0;
  localparam logic [KIND_W-1:0] OP_SUB  = 4'd1;
  localparam logic [KIND_W-1:0] OP_AND  = 4'd2;
  localparam logic [KIND_W-1:0] OP_OR   = 4'd3;
  localparam logic [KIND_W-1:0] OP_XOR  = 4'd4;
  localparam logic [KIND_W-1:0] OP_NAND = 4'd5;
  localparam logic [KIND_W-1:0] OP_SMAX = 4'd6;
  localparam logic [KIND_W-1:0] OP_SMIN = 4'd7;
  localparam logic [KIND_W-1:0] OP_UMAX = 4'd8;
  localparam logic [KIND_W-1:0] OP_UMIN = 4'd9;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SIZE_W-1:0] size_bytes;
    logic [DATA_W-1:0] current_value;
    logic [DATA_W-1:0] operand;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] previous_value;
    logic [DATA_W-1:0] updated_value;
  } rsp_t;

endpackage

// ===== rtl/afo_req_if.sv =====
interface afo_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [3:0]  size_bytes;
  logic [63:0] current_value;
  logic [63:0] operand;

  modport source(output valid, output kind, output size_bytes, output current_value,
                 output operand, input ready);
  modport sink(input valid, input kind, input size_bytes, input current_value,
               input operand, output ready);
endinterface

// ===== rtl/afo_rsp_if.sv =====
interface afo_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] previous_value;
  logic [63:0] updated_value;

  modport source(output valid, output previous_value, output updated_value, input ready);
  modport sink(input valid, input previous_value, input updated_value, output ready);
endinterface

// ===== rtl/afo_alu.sv =====
module afo_alu (
  input  afo_pkg::req_t req,
  output afo_pkg::rsp_t rsp
);

  logic [afo_pkg::SIZE_W-1:0] n;
  logic [afo_pkg::DATA_W-1:0] mask;
  logic [afo_pkg::DATA_W-1:0] cur;
  logic [afo_pkg::DATA_W-1:0] op;
  logic [afo_pkg::DATA_W-1:0] nv;
  logic                       sign_c;
  logic                       sign_o;
  logic                       ult;
  logic                       ugt;
  logic                       slt;
  logic                       sgt;

  always_comb begin
    if (req.size_bytes > afo_pkg::SIZE_W'(afo_pkg::MAX_BYTES)) begin
      n = afo_pkg::SIZE_W'(afo_pkg::MAX_BYTES);
    end else begin
      n = req.size_bytes;
    end
    for (int i = 0; i < 8; i++) begin
      mask[8*i +: 8] = {8{afo_pkg::SIZE_W'(i) < n}};
    end
  end

  assign cur = req.current_value & mask;
  assign op  = req.operand & mask;

  // sign from bit 7 of the top byte in use
  always_comb begin
    sign_c = 1'b0;
    sign_o = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (n == afo_pkg::SIZE_W'(i + 1)) begin
        sign_c = cur[8*i + 7];
        sign_o = op[8*i + 7];
      end
    end
  end

  assign ult = cur < op;
  assign ugt = cur > op;
  assign slt = (sign_c != sign_o) ? sign_c : ult;
  assign sgt = (sign_c != sign_o) ? sign_o : ugt;

  always_comb begin
    case (req.kind)
      afo_pkg::OP_ADD:  nv = cur + op;
      afo_pkg::OP_SUB:  nv = cur - op;
      afo_pkg::OP_AND:  nv = cur & op;
      afo_pkg::OP_OR:   nv = cur | op;
      afo_pkg::OP_XOR:  nv = cur ^ op;
      afo_pkg::OP_NAND: nv = ~(cur & op);
      afo_pkg::OP_SMAX: nv = slt ? op : cur;
      afo_pkg::OP_SMIN: nv = sgt ? op : cur;
      afo_pkg::OP_UMAX: nv = ult ? op : cur;
      afo_pkg::OP_UMIN: nv = ugt ? op : cur;
      default:          nv = cur;
    endcase
  end

  assign rsp.previous_value = cur;
  assign rsp.updated_value  = nv & mask;

endmodule

// ===== rtl/atomic_fetch_op_alu_unit.sv =====
// stages: an accepted beat goes to the input register, then its result to the result register
// throughput: one beat per cycle while rsp.ready holds, set by the single 64-bit add/compare pass
// between the input register and the result register
// reset (synchronous, active high) empties both stages; data registers hold
module atomic_fetch_op_alu_unit (
  input  logic      clk,
  input  logic      rst,
  afo_req_if.sink   req,
  afo_rsp_if.source rsp
);

  logic          s1_valid;
  afo_pkg::req_t s1_data;
  afo_pkg::rsp_t alu_out;
  logic          out_valid;
  afo_pkg::rsp_t out_data;
  logic          advance;

  assign advance   = !out_valid || rsp.ready;
  assign req.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
    if (req.ready && req.valid) begin
      s1_data.kind          <= req.kind;
      s1_data.size_bytes    <= req.size_bytes;
      s1_data.current_value <= req.current_value;
      s1_data.operand       <= req.operand;
    end
  end

  afo_alu u_alu (
    .req(s1_data),
    .rsp(alu_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
    if (advance && s1_valid) begin
      out_data <= alu_out;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.previous_value = out_data.previous_value;
  assign rsp.updated_value  = out_data.updated_value;

`ifndef SYNTHESIS
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_data))
    else $error("input stage lost or changed a stalled beat");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && advance |=> out_valid)
    else $error("beat dropped between stages");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && rsp.ready && !s1_valid |=> !out_valid)
    else $error("result repeated after it was taken");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !s1_valid)
    else $error("stages not empty after reset");
`endif

endmodule
